[rtl/mrle_pkg.sv]
// ----------------------------------------------------------------------------
// mrle_pkg
// Shared types, constants and helpers of the marker run-length encoder.
// ----------------------------------------------------------------------------
package mrle_pkg;

  localparam int unsigned MAX_ELEMENT_BYTES = 4;
  localparam int unsigned ELEM_W            = 32;
  localparam int unsigned COUNT_W           = 8;
  localparam int unsigned BYTES_W           = 3;
  localparam int unsigned LIT_W             = 3;   // literal burst index, up to 5 copies
  localparam int unsigned QDEPTH            = 4;
  localparam int unsigned QPTR_W            = $clog2(QDEPTH);
  localparam int unsigned QCNT_W            = $clog2(QDEPTH + 1);

  localparam logic [7:0]         MARKER_BYTE = 8'hFE;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;
  localparam logic [COUNT_W-1:0] SHORT_EXTRA = 8'd2;

  // One command for the back end: a run token, or a burst of literal copies.
  typedef struct packed {
    logic               is_run;
    logic [COUNT_W-1:0] count;
    logic [ELEM_W-1:0]  elem;
  } mrle_cmd_t;

  // Everything one input item causes: first command always valid.
  typedef struct packed {
    mrle_cmd_t a;
    mrle_cmd_t b;
    logic      b_valid;
    logic      eos;
  } mrle_entry_t;

  typedef enum logic {
    PH_A,
    PH_B
  } mrle_phase_t;

  function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] raw);
    logic [BYTES_W-1:0] b;
    b = raw;
    if (b == '0) begin
      b = BYTES_W'(1);
    end
    if (b > BYTES_W'(MAX_ELEMENT_BYTES)) begin
      b = BYTES_W'(MAX_ELEMENT_BYTES);
    end
    if (b > BYTES_W'(4)) begin
      b = BYTES_W'(4);
    end
    return b;
  endfunction

  function automatic logic [ELEM_W-1:0] elem_mask(input logic [BYTES_W-1:0] bytes);
    logic [ELEM_W-1:0] m;
    unique case (bytes)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/mrle_front.sv]
// ----------------------------------------------------------------------------
// mrle_front
// Tracks the open run and turns accepted elements into queue entries, at most one per element.
// ----------------------------------------------------------------------------
module mrle_front import mrle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ELEM_W-1:0]   s_tdata,     // in_element
  input  logic                s_tlast,     // final_element
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BYTES_W-1:0]  cfg_data,    // element_bytes
  input  logic                q_full,
  output logic                push,
  output mrle_entry_t         push_entry
);

  logic [BYTES_W-1:0] element_bytes;
  logic [ELEM_W-1:0]  held_element;
  logic [COUNT_W-1:0] run_length;
  logic               have_element;
  logic               split_run;

  logic [ELEM_W-1:0]  held_next;
  logic [COUNT_W-1:0] run_next;
  logic               have_next;
  logic               split_next;

  logic [BYTES_W-1:0] bytes;
  logic [ELEM_W-1:0]  mask;
  logic [ELEM_W-1:0]  e;
  logic               match;
  logic [COUNT_W-1:0] run_inc;
  logic               hit;
  logic [COUNT_W-1:0] short_limit;
  logic               accept;

  // merged state, before the final flush
  logic [ELEM_W-1:0]  m_held;
  logic [COUNT_W-1:0] m_run;
  logic               m_split;

  mrle_cmd_t cmd_x;
  logic      x_valid;
  mrle_cmd_t cmd_y;
  logic      y_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    bytes       = eff_bytes(element_bytes);
    mask        = elem_mask(bytes);
    e           = s_tdata & mask;
    match       = have_element && (e == (held_element & mask));
    run_inc     = run_length + COUNT_W'(1);
    hit         = match && (run_inc >= COUNT_LIMIT);
    short_limit = COUNT_W'(bytes) + SHORT_EXTRA;

    // close the old run, or cut a full 255 token
    cmd_x   = '0;
    x_valid = 1'b0;
    if (match) begin
      cmd_x.is_run = 1'b1;
      cmd_x.count  = COUNT_LIMIT;
      cmd_x.elem   = held_element;
      x_valid      = hit;
    end else begin
      cmd_x.is_run = split_run || (run_length >= short_limit) ||
                     (held_element[7:0] == MARKER_BYTE);
      cmd_x.count  = run_length;
      cmd_x.elem   = held_element;
      x_valid      = have_element && (run_length != '0);
    end

    if (match) begin
      m_held  = held_element;
      m_run   = hit ? '0 : run_inc;
      m_split = split_run || hit;
    end else begin
      m_held  = e;
      m_run   = COUNT_W'(1);
      m_split = 1'b0;
    end

    // final flush of the merged run
    cmd_y.is_run = m_split || (m_run >= short_limit) || (m_held[7:0] == MARKER_BYTE);
    cmd_y.count  = m_run;
    cmd_y.elem   = m_held;
    y_valid      = s_tlast && (m_run != '0);

    push_entry         = '0;
    push_entry.eos     = s_tlast;
    if (x_valid) begin
      push_entry.a       = cmd_x;
      push_entry.b       = cmd_y;
      push_entry.b_valid = y_valid;
    end else begin
      push_entry.a       = cmd_y;
    end
    push = accept && (x_valid || y_valid);

    if (s_tlast) begin
      held_next  = '0;
      run_next   = '0;
      have_next  = 1'b0;
      split_next = 1'b0;
    end else begin
      held_next  = m_held;
      run_next   = m_run;
      have_next  = 1'b1;
      split_next = m_split;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= BYTES_W'(1);
      held_element  <= '0;
      run_length    <= '0;
      have_element  <= 1'b0;
      split_run     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        element_bytes <= cfg_data;
      end
      if (accept) begin
        held_element <= held_next;
        run_length   <= run_next;
        have_element <= have_next;
        split_run    <= split_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("front pushed into a full queue");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (!have_element && run_length == '0 && !split_run))
    else $error("run state not cleared after final element");

  a_final_has_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |-> push)
    else $error("final element caused no result");
`endif

endmodule

[rtl/mrle_queue.sv]
// ----------------------------------------------------------------------------
// mrle_queue
// Short register queue of command entries between front and back end.
// ----------------------------------------------------------------------------
module mrle_queue import mrle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mrle_entry_t push_entry,
  input  logic        pop,
  output logic        q_valid,
  output logic        q_full,
  output mrle_entry_t head
);

  mrle_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign q_valid = (fill != '0);
  assign q_full  = (fill == QCNT_W'(QDEPTH));
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QDEPTH))
    else $error("queue fill out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (!q_full && q_valid) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with fill");
`endif

endmodule

[rtl/mrle_back.sv]
// ----------------------------------------------------------------------------
// mrle_back
// Expands queue entries into result items and holds the output register.
// ----------------------------------------------------------------------------
module mrle_back import mrle_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  mrle_entry_t               head,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [COUNT_W+ELEM_W-1:0] m_tdata,   // run_count, out_element
  output logic                      m_tuser,   // is_run
  output logic                      m_tlast    // end_of_stream
);

  mrle_phase_t       phase;
  mrle_phase_t       phase_next;
  logic [LIT_W-1:0]  done;
  logic [LIT_W-1:0]  done_next;

  mrle_cmd_t          cur;
  logic               out_free;
  logic               issue;
  logic               last_cur;
  logic               last_entry;
  logic [COUNT_W-1:0] res_count;

  assign out_free = !m_tvalid || m_tready;
  assign issue    = q_valid && out_free;

  // output decode
  always_comb begin
    cur        = (phase == PH_B) ? head.b : head.a;
    last_cur   = cur.is_run || (done == LIT_W'(cur.count - COUNT_W'(1)));
    last_entry = last_cur && ((phase == PH_B) || !head.b_valid);
    res_count  = cur.is_run ? cur.count : COUNT_W'(1);
    pop        = issue && last_entry;
  end

  // next state
  always_comb begin
    phase_next = phase;
    done_next  = done;
    if (issue) begin
      priority if (last_entry) begin
        phase_next = PH_A;
        done_next  = '0;
      end else if (last_cur) begin
        phase_next = PH_B;
        done_next  = '0;
      end else begin
        done_next  = done + LIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_A;
      done     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= done_next;
      if (out_free) begin
        m_tvalid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_tdata <= {cur.elem, res_count};
      m_tuser <= cur.is_run;
      m_tlast <= head.eos && last_entry;
    end
  end

`ifndef SYNTHESIS
  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[COUNT_W-1:0] == COUNT_W'(1)))
    else $error("literal result with count other than one");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !cur.is_run) |-> (COUNT_W'(done) < cur.count))
    else $error("literal burst ran past its count");

  a_phase_b_valid: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_B) |-> (q_valid && head.b_valid))
    else $error("second command phase without a second command");
`endif

endmodule

[rtl/marker_rle_encoder.sv]
// ----------------------------------------------------------------------------
// marker_rle_encoder
// Escape-marker run-length encoder, one element of 1 to 4 bytes per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries elements (tdata) with tlast on the last element of a stream.
//   m_* carries results: tuser high for a run token (marker, count, element),
//   low for one literal copy (count 1); tlast marks the last result of a
//   stream. cfg_* writes element_bytes; write it only while the block is idle.
// Path: the results caused by an item enter the queue with it at the accepting
//   edge and are then written into the output register that drives m_tvalid.
// Throughput: one item per cycle while the queue is not full. The back end
//   issues one result per cycle while the output is free, so a closed short run
//   makes up to five literal results; the four-entry queue between front and back
//   absorbs those bursts, and s_tready drops only while the queue is full.
// Reset: element_bytes returns to 1, no run is open, the queue and the
//   output register are empty.
// Stall: when m_tready is low the output register holds its result, the
//   queue fills, and then s_tready goes low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module marker_rle_encoder import mrle_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ELEM_W-1:0]         s_tdata,    // in_element
  input  logic                      s_tlast,    // final_element
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [COUNT_W+ELEM_W-1:0] m_tdata,    // run_count [7:0], out_element [39:8]
  output logic                      m_tuser,    // is_run
  output logic                      m_tlast,    // end_of_stream
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [BYTES_W-1:0]        cfg_data    // element_bytes
);

  logic        push;
  mrle_entry_t push_entry;
  logic        pop;
  logic        q_valid;
  logic        q_full;
  mrle_entry_t head;

  mrle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mrle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  mrle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[tb/tb_marker_rle_encoder.sv]
// ----------------------------------------------------------------------------
// tb_marker_rle_encoder
// Self-checking bench for the marker run-length encoder. A cycle-free
// predictor tracks the open run and the element size, queues the tokens and
// literals each accepted element should produce, and every output item is
// compared against the oldest queued one. Directed streams cover short and
// marker runs, widest elements and size clamping. Long runs cover the
// 255-count split. Random streams cover all sizes with idling on both sides,
// and the backpressure test holds one long output stall.
// ----------------------------------------------------------------------------
module tb_marker_rle_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mrle_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 80;
  localparam int PHASE_ITEMS  = 8;

  typedef struct packed {
    logic               is_run;
    logic [COUNT_W-1:0] count;
    logic [ELEM_W-1:0]  elem;
    logic               eos;
  } token_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [ELEM_W-1:0]         s_tdata   = '0;
  logic                      s_tlast   = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [COUNT_W+ELEM_W-1:0] m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [BYTES_W-1:0]        cfg_data  = '0;

  // predictor state
  logic [BYTES_W-1:0] size_reg;
  logic [ELEM_W-1:0]  run_elem;
  int unsigned        run_len;
  logic               run_open;
  logic               run_split;
  token_t             pending_tokens[$];

  // idling control
  logic        tx_idle_en   = 1'b1;
  logic        rx_idle_en   = 1'b1;
  int unsigned stall_ticket = 0;
  int unsigned stall_seen   = 0;
  int          rx_gap       = 0;

  // bookkeeping
  int   errors        = 0;
  int   elements_sent = 0;
  int   results_seen  = 0;
  int   runs_seen     = 0;
  int   ends_seen     = 0;
  logic [7:0] sizes_written = '0;

  marker_rle_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_bytes();
    int unsigned b;
    b = size_reg;
    if (b == 0) begin
      b = 1;
    end
    if (b > MAX_ELEMENT_BYTES) begin
      b = MAX_ELEMENT_BYTES;
    end
    if (b > 4) begin
      b = 4;
    end
    return b;
  endfunction

  function automatic logic [ELEM_W-1:0] lane_mask(input int unsigned nbytes);
    return ELEM_W'((64'd1 << (nbytes * 8)) - 64'd1);
  endfunction

  function automatic void close_run(input int unsigned nbytes);
    if (!run_open || run_len == 0) begin
      return;
    end
    if (!run_split && run_len < nbytes + SHORT_EXTRA && run_elem[7:0] != MARKER_BYTE) begin
      for (int i = 0; i < run_len; i++) begin
        pending_tokens.push_back(token_t'{1'b0, COUNT_W'(1), run_elem, 1'b0});
      end
    end else begin
      pending_tokens.push_back(token_t'{1'b1, COUNT_W'(run_len), run_elem, 1'b0});
    end
    run_len = 0;
  endfunction

  function automatic void encode_element(input logic [ELEM_W-1:0] data, input logic fin);
    int unsigned       nbytes;
    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] e;
    int                first;
    token_t            last_tok;
    nbytes = active_bytes();
    mask   = lane_mask(nbytes);
    e      = data & mask;
    first  = pending_tokens.size();
    if (run_open && e == (run_elem & mask)) begin
      run_len++;
      if (run_len >= COUNT_LIMIT) begin
        pending_tokens.push_back(token_t'{1'b1, COUNT_LIMIT, run_elem, 1'b0});
        run_len   = 0;
        run_split = 1'b1;
      end
    end else begin
      close_run(nbytes);
      run_elem  = e;
      run_len   = 1;
      run_split = 1'b0;
      run_open  = 1'b1;
    end
    if (fin) begin
      close_run(nbytes);
      run_elem  = '0;
      run_len   = 0;
      run_open  = 1'b0;
      run_split = 1'b0;
      // flag the last result of this element as end of stream
      if (pending_tokens.size() > first) begin
        last_tok     = pending_tokens.pop_back();
        last_tok.eos = 1'b1;
        pending_tokens.push_back(last_tok);
      end
    end
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
                             input logic [ELEM_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    token_t got;
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = token_t'{m_tuser, m_tdata[COUNT_W-1:0], m_tdata[COUNT_W+ELEM_W-1:COUNT_W], m_tlast};
      results_seen++;
      if (got.is_run) begin
        runs_seen++;
      end
      if (got.eos) begin
        ends_seen++;
      end
      if (pending_tokens.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual run=%0b count=%0d elem=0x%0h",
                 $time, got.is_run, got.count, got.elem);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("is_run", ELEM_W'(want.is_run), ELEM_W'(got.is_run));
        check_field("run_count", ELEM_W'(want.count), ELEM_W'(got.count));
        check_field("out_element", want.elem, got.elem);
        check_field("end_of_stream", ELEM_W'(want.eos), ELEM_W'(got.eos));
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  function automatic int idle_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // stall requests arrive as ticket bumps; hold m_tready low for a counted stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else if (stall_ticket != stall_seen) begin
      stall_seen <= stall_ticket;
      rx_gap     <= STALL_CYCLES - 1;
      m_tready   <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap   <= idle_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------- sender

  task automatic send_element(input logic [ELEM_W-1:0] data, input logic fin);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = idle_gap();
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_element(data, fin);
    elements_sent++;
  endtask

  // send len copies of base; with noise, scramble bytes above the element size
  task automatic send_run(input logic [ELEM_W-1:0] base, input int len, input logic fin,
                          input logic noise);
    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] data;
    mask = lane_mask(active_bytes());
    for (int i = 0; i < len; i++) begin
      data = base;
      if (noise && $urandom_range(0, 2) == 0) begin
        data = (base & mask) | ($urandom & ~mask);
      end
      send_element(data, fin && (i == len - 1));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [BYTES_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = value;
    sizes_written[value] = 1'b1;
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_short_runs();
    write_size(BYTES_W'(1));
    send_run(32'h0000_0000, 1, 1'b0, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h1234_56FF, 1'b0);    // same element once masked
    send_run(32'h0000_00FE, 1, 1'b0, 1'b0);
    send_run(32'h0000_0011, 3, 1'b0, 1'b0);
    send_run(32'h0000_0022, 1, 1'b1, 1'b0);
  endtask

  task automatic test_wide_elements();
    write_size(BYTES_W'(4));
    // five literals flushed plus a literal on final: the largest burst
    send_run(32'hFFFF_FFFF, 5, 1'b0, 1'b0);
    send_run(32'h0000_0000, 1, 1'b1, 1'b0);
    send_run(32'h0000_00FE, 1, 1'b0, 1'b0);
    send_run(32'hABCD_EF01, 6, 1'b1, 1'b0);
  endtask

  task automatic test_size_clamp();
    write_size(BYTES_W'(0));
    send_element(32'h1234_5601, 1'b0);
    send_element(32'hABCD_EF01, 1'b1);
    write_size(BYTES_W'(7));
    send_run(32'h0102_0304, 1, 1'b1, 1'b0);
  endtask

  task automatic test_long_runs();
    logic [ELEM_W-1:0] a;
    a = $urandom;
    write_size(BYTES_W'(1));
    // a full 255 token on the way, then the single leftover still as a token
    send_run(a, COUNT_LIMIT + 1, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [ELEM_W-1:0] base;
    write_size(BYTES_W'(2));
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    stall_ticket <= stall_ticket + 1;
    for (int i = 0; i < 16; i++) begin
      base = $urandom;
      send_run(base, $urandom_range(1, 3), i == 15, 1'b1);
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_random_streams();
    logic [BYTES_W-1:0] phase_size[7];
    logic [ELEM_W-1:0]  base;
    int                 sent;
    int                 len;
    int                 nbytes;
    phase_size = '{3'd1, 3'd3, 3'd2, 3'd4, 3'd0, 3'd7, 3'd2};
    base = $urandom;
    for (int p = 0; p < 7; p++) begin
      // an open run carries over the size change
      write_size(phase_size[p]);
      tx_idle_en = (p != 3);
      rx_idle_en <= (p != 3);
      nbytes = active_bytes();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(8, 20);
        end else begin
          len = $urandom_range(1, nbytes + 3);
        end
        if ($urandom_range(0, 4) != 0) begin
          base = $urandom;
          if ($urandom_range(0, 5) == 0) begin
            base[7:0] = MARKER_BYTE;
          end
        end
        send_run(base, len, $urandom_range(0, 7) == 0, nbytes < 4);
        sent += len;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    size_reg  = BYTES_W'(1);
    run_elem  = '0;
    run_len   = 0;
    run_open  = 1'b0;
    run_split = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_runs();
    test_wide_elements();
    test_size_clamp();
    test_long_runs();
    test_backpressure();
    test_random_streams();

    drain();
    $display("Sent %0d elements under element-size settings 0x%0h (bit per value).",
             elements_sent, sizes_written);
    $display("Checked %0d results: %0d run tokens, %0d literals, %0d stream ends.",
             results_seen, runs_seen, results_seen - runs_seen, ends_seen);
    if (errors == 0 && pending_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("Timeout with %0d results still expected", pending_tokens.size());
    $display("FAIL");
    $finish;
  end

endmodule

[marker_rle_encoder.f]
rtl/mrle_pkg.sv
rtl/mrle_front.sv
rtl/mrle_queue.sv
rtl/mrle_back.sv
rtl/marker_rle_encoder.sv
tb/tb_marker_rle_encoder.sv
